// ----- rtl/start_stop_key_lamp_controller_defines.svh -----
// assertion macros shared by the start/stop key lamp controller modules
// no dependencies; taken in by the modules that carry assertions
`ifndef START_STOP_KEY_LAMP_CONTROLLER_DEFINES_SVH
`define START_STOP_KEY_LAMP_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SSKL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SSKL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sskl_pkg.sv -----
// shared types and constants of the start/stop key lamp controller
// no dependencies
package sskl_pkg;

    localparam int unsigned TickW  = 16;
    localparam int unsigned BlinkW = 8;

    // register reset values
    localparam logic [TickW-1:0]  ShortTicksRst = 16'd10;
    localparam logic [TickW-1:0]  LongTicksRst  = 16'd300;
    localparam logic [BlinkW-1:0] BlinkTicksRst = 8'd100;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SHORT_TICKS = 2'd0,
        CFG_LONG_TICKS  = 2'd1,
        CFG_BLINK_TICKS = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        MODE_RUN   = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_FAULT = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_START_SHORT = 3'd1,
        EV_START_LONG  = 3'd2,
        EV_STOP_SHORT  = 3'd3,
        EV_STOP_LONG   = 3'd4
    } t_key_event;

    // what a key tracker reports for the current tick
    typedef struct packed {
        logic short_ev;
        logic long_ev;
        logic resolved;
    } t_key_status;

    // one result beat
    typedef struct packed {
        t_mode      device_mode;
        logic       start_lamp;
        logic       stop_lamp;
        t_key_event key_event;
        logic       clear_fault_bit;
    } t_result;

endpackage

// ----- rtl/sskl_key_track.sv -----
// press tracker for one key: phase, hold counter, short and long detection
// depends on sskl_pkg and the assertion macro header
`include "start_stop_key_lamp_controller_defines.svh"

module sskl_key_track
    import sskl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_enable,
    input  logic             i_pressed,
    input  logic             i_hold_on_release,
    input  logic [TickW-1:0] i_short_ticks,
    input  logic [TickW-1:0] i_long_ticks,
    output t_key_status      o_status
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_COUNT = 2'd1,
        PH_LONG  = 2'd2
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [TickW-1:0] r_cnt, n_cnt;
    logic [TickW-1:0] cnt_inc;
    t_key_status      status;

    assign cnt_inc = r_cnt + 16'd1;

    // next phase and count for this tick
    always_comb begin
        n_phase         = r_phase;
        n_cnt           = r_cnt;
        status          = '0;
        if (i_pressed) begin
            unique case (r_phase)
                PH_IDLE: n_phase = PH_COUNT;
                PH_COUNT: begin
                    if (cnt_inc > i_long_ticks) begin
                        n_phase         = PH_LONG;
                        n_cnt           = '0;
                        status.long_ev  = 1'b1;
                        status.resolved = 1'b1;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                default: ;
            endcase
        end else if (r_phase != PH_IDLE) begin
            status.short_ev = (r_phase == PH_COUNT) && (r_cnt >= i_short_ticks)
                              && (r_cnt < i_long_ticks);
            status.resolved = 1'b1;
            n_phase         = PH_IDLE;
            if (!i_hold_on_release) begin
                n_cnt = '0;
            end
        end else begin
            n_cnt = '0;
        end
    end

    assign o_status = i_enable ? status : '0;

    // state update on each evaluated beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
        end else if (i_accept && i_enable) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    `SSKL_ASSERT_SAME(a_long_cnt_zero, i_clk, i_rst_n, r_phase == PH_LONG, r_cnt == '0,
        "hold count not cleared after long press")
    `SSKL_ASSERT_NEXT(a_long_phase, i_clk, i_rst_n, i_accept && o_status.long_ev,
        r_phase == PH_LONG, "long press did not latch")

endmodule

// ----- rtl/sskl_lamp_ctrl.sv -----
// device mode, lamp drive and fault blink, builds one result per tick
// depends on sskl_pkg
module sskl_lamp_ctrl
    import sskl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_upper_limit_hit,
    input  t_key_status       i_start_status,
    input  t_key_status       i_stop_status,
    input  logic [BlinkW-1:0] i_blink_ticks,
    output t_result           o_result
);

    t_mode             r_mode, n_mode;
    logic [BlinkW-1:0] r_blink_cnt, n_blink_cnt;
    logic              r_blink_phase, n_blink_phase;
    logic              r_stop_lamp, n_stop_lamp;
    logic              r_start_lamp, n_start_lamp;
    logic              clear_bit;
    t_key_event        key_event;

    // event code, start key first
    always_comb begin
        if (i_start_status.long_ev) begin
            key_event = EV_START_LONG;
        end else if (i_start_status.short_ev) begin
            key_event = EV_START_SHORT;
        end else if (i_stop_status.long_ev) begin
            key_event = EV_STOP_LONG;
        end else if (i_stop_status.short_ev) begin
            key_event = EV_STOP_SHORT;
        end else begin
            key_event = EV_NONE;
        end
    end

    // mode change and lamp drive
    always_comb begin
        n_mode        = r_mode;
        n_blink_cnt   = r_blink_cnt;
        n_blink_phase = r_blink_phase;
        n_stop_lamp   = r_stop_lamp;
        n_start_lamp  = r_start_lamp;
        clear_bit     = 1'b0;
        case (key_event) inside
            EV_START_SHORT, EV_START_LONG: begin
                if (r_mode != MODE_FAULT) begin
                    n_mode = i_upper_limit_hit ? MODE_FAULT : MODE_RUN;
                end
            end
            EV_STOP_SHORT, EV_STOP_LONG: n_mode = MODE_STOP;
            default: ;
        endcase
        unique case (n_mode)
            MODE_RUN: begin
                n_start_lamp = 1'b1;
                n_stop_lamp  = 1'b0;
            end
            MODE_STOP: begin
                n_start_lamp = 1'b0;
                n_stop_lamp  = 1'b1;
                clear_bit    = 1'b1;
            end
            default: begin
                n_start_lamp = 1'b0;
                if (r_blink_cnt != '0) begin
                    n_blink_cnt = r_blink_cnt - 8'd1;
                end else begin
                    n_blink_cnt   = i_blink_ticks;
                    n_stop_lamp   = !r_blink_phase;
                    n_blink_phase = !r_blink_phase;
                end
            end
        endcase
    end

    assign o_result.device_mode     = n_mode;
    assign o_result.start_lamp      = n_start_lamp;
    assign o_result.stop_lamp       = n_stop_lamp;
    assign o_result.key_event       = key_event;
    assign o_result.clear_fault_bit = clear_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_STOP;
            r_blink_cnt   <= BlinkTicksRst;
            r_blink_phase <= 1'b0;
            r_stop_lamp   <= 1'b0;
            r_start_lamp  <= 1'b0;
        end else if (i_accept) begin
            r_mode        <= n_mode;
            r_blink_cnt   <= n_blink_cnt;
            r_blink_phase <= n_blink_phase;
            r_stop_lamp   <= n_stop_lamp;
            r_start_lamp  <= n_start_lamp;
        end
    end

endmodule

// ----- rtl/sskl_out_skid.sv -----
// result register with a skid stage, so a new beat enters while one waits
// depends on sskl_pkg and the assertion macro header
`include "start_stop_key_lamp_controller_defines.svh"

module sskl_out_skid
    import sskl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_result i_data,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_result o_data,
    input  logic    i_out_stall
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    in_take, out_free;

    assign in_take  = i_in_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || in_take;
            r_skid_valid <= 1'b0;
        end else if (in_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (in_take) begin
            r_skid <= i_data;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_data      = r_out;

    `SSKL_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid stage full while result register empty")
    `SSKL_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && !i_out_stall,
        !r_skid_valid && r_out_valid, "skid beat not moved to result register")

endmodule

// ----- rtl/start_stop_key_lamp_controller.sv -----
// Start/stop key lamp controller. Each input beat is one scan tick with the
// start key, stop key and upper-limit levels; each tick gives exactly one
// result beat with the device mode, both lamp drives, the key event and the
// fault-bit clear request. A new tick is taken every clock cycle unless o_in_stall
// is high. The key trackers and mode logic are combinational; the result is
// registered in a two-entry output buffer (result register plus skid stage)
// that lets a tick enter while a result waits; o_in_stall rises only when both
// entries are full. The configuration port is always ready; the user writes it
// only while no tick is in flight, which the block itself does not enforce.
// Depends on sskl_pkg, sskl_key_track, sskl_lamp_ctrl and sskl_out_skid.
module start_stop_key_lamp_controller
    import sskl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick beats
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_start_pressed,
    input  logic        i_stop_pressed,
    input  logic        i_upper_limit_hit,
    // result beats
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_device_mode,
    output logic        o_start_lamp,
    output logic        o_stop_lamp,
    output logic [2:0]  o_key_event,
    output logic        o_clear_fault_bit,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [TickW-1:0]  r_short_ticks, r_long_ticks;
    logic [BlinkW-1:0] r_blink_ticks;
    logic              in_accept;
    t_key_status       start_status, stop_status;
    t_result           result, out_data;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_ticks <= ShortTicksRst;
            r_long_ticks  <= LongTicksRst;
            r_blink_ticks <= BlinkTicksRst;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SHORT_TICKS: r_short_ticks <= i_cfg_data;
                CFG_LONG_TICKS:  r_long_ticks  <= i_cfg_data;
                CFG_BLINK_TICKS: r_blink_ticks <= i_cfg_data[BlinkW-1:0];
                default: ;
            endcase
        end
    end

    // start key keeps its count for one tick after release
    sskl_key_track u_start_key (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_enable          (1'b1),
        .i_pressed         (i_start_pressed),
        .i_hold_on_release (1'b1),
        .i_short_ticks     (r_short_ticks),
        .i_long_ticks      (r_long_ticks),
        .o_status          (start_status)
    );

    // stop key is skipped on ticks where the start key resolves
    sskl_key_track u_stop_key (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_enable          (!start_status.resolved),
        .i_pressed         (i_stop_pressed),
        .i_hold_on_release (1'b0),
        .i_short_ticks     (r_short_ticks),
        .i_long_ticks      (r_long_ticks),
        .o_status          (stop_status)
    );

    sskl_lamp_ctrl u_lamp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_upper_limit_hit (i_upper_limit_hit),
        .i_start_status    (start_status),
        .i_stop_status     (stop_status),
        .i_blink_ticks     (r_blink_ticks),
        .o_result          (result)
    );

    sskl_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_data      (result),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_data      (out_data),
        .i_out_stall (i_out_stall)
    );

    assign o_device_mode     = out_data.device_mode;
    assign o_start_lamp      = out_data.start_lamp;
    assign o_stop_lamp       = out_data.stop_lamp;
    assign o_key_event       = out_data.key_event;
    assign o_clear_fault_bit = out_data.clear_fault_bit;

endmodule
